// ===== hw/rtl/pdf_pkg.sv =====
// pdf_pkg: shared constants and types of the projection distance filter
// field widths, register indexes and reset values, operation codes
// no dependencies
package pdf_pkg;

	localparam int POINT_W    = 10;
	localparam int SLOT_IN_W  = 4;
	localparam int COORD_W    = 32;
	localparam int RADIUS_W   = 32;
	localparam int THR_W      = 32;
	localparam int DIMS_REG_W = 5;
	localparam int DIST_W     = 64;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int DIMS_DEF       = 16;

	localparam logic [THR_W-1:0]      THRESHOLD_RST = 32'd1723335;
	localparam logic [DIMS_REG_W-1:0] DIMS_RST      = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_DIMS      = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

endpackage

// ===== hw/rtl/projection_distance_filter.sv =====
// projection_distance_filter: projected squared distance and pair filter
// holds two copies of the coordinate store in pdf_ram, uses pdf_pkg
//
//  channel  | direction | handshake              | carries
//  ---------+-----------+------------------------+----------------------------------
//  in       | input     | in_valid / in_ready    | op, points, slot, coord, radii
//  out      | output    | out_valid / out_ready  | filter_pair, distance_sq
//  cfg      | input     | cfg_we                 | cfg_index, cfg_wdata
//
// a write passes ST_RED1 and ST_RED2 and returns to ST_IDLE; a query also reads m pairs,
// m being dims_in_use clamped to 1..DIMS, one pair per cycle from the store copies
// the store is undefined after reset and needs no clearing pass
// a finished result waits in the output register while the next transaction is taken
module projection_distance_filter #(
	parameter int MAX_POINTS = pdf_pkg::MAX_POINTS_DEF,
	parameter int DIMS       = pdf_pkg::DIMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [pdf_pkg::POINT_W-1:0]     point_a,
	input  logic [pdf_pkg::POINT_W-1:0]     point_b,
	input  logic [pdf_pkg::SLOT_IN_W-1:0]   slot,
	input  logic signed [pdf_pkg::COORD_W-1:0] coord_value,
	input  logic [pdf_pkg::RADIUS_W-1:0]    radius_a,
	input  logic [pdf_pkg::RADIUS_W-1:0]    radius_b,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            filter_pair,
	output logic [pdf_pkg::DIST_W-1:0]      distance_sq
);

	import pdf_pkg::*;

	localparam int PT_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SLOT_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int DEPTH   = MAX_POINTS * (2 ** SLOT_W);
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int RECIP   = ((2 ** 20) + MAX_POINTS - 1) / MAX_POINTS;
	localparam logic [6:0] DIMS_V = 7'(DIMS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RED1  = 6'b000010,
		ST_RED2  = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_CMP   = 6'b100000
	} state_t;

	state_t state_q;

	logic [THR_W-1:0]      thr_q;
	logic [DIMS_REG_W-1:0] dims_q;

	logic                  op_q;
	logic [POINT_W-1:0]    pa_raw_q, pb_raw_q;
	logic [SLOT_IN_W-1:0]  slot_q;
	logic [COORD_W-1:0]    coord_q;
	logic [RADIUS_W-1:0]   ra_q, rb_q;

	logic [10:0]           qa_q, qb_q;
	logic [PT_W-1:0]       pa_q, pb_q;
	logic [SLOT_W-1:0]     j_q, last_q;

	logic [63:0]           r2a_q, r2b_q;
	logic [63:0]           pla_q, pha_q, plb_q, phb_q;
	logic [95:0]           prod_a_q, prod_b_q;

	logic                  v_s1, v_s2, v_s3;
	logic [31:0]           ad_s2;
	logic [63:0]           sq_s3;
	logic [DIST_W-1:0]     sum_q;

	logic                  out_valid_q, filter_q;
	logic [DIST_W-1:0]     dist_q;

	logic [COORD_W-1:0]    rdata_a, rdata_b;
	logic                  ram_we, ram_re;
	logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;

	logic [30:0]           qa_prod, qb_prod;
	logic [31:0]           ra_rem, rb_rem;
	logic [6:0]            dims_ext, last7;
	logic                  slot_ok;
	logic signed [32:0]    diff;
	logic [32:0]           mag;
	logic [64:0]           sum_ext;
	logic                  exceed_a, exceed_b;
	logic                  out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			dims_q <= DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_wdata[THR_W-1:0];
				REG_DIMS:      dims_q <= cfg_wdata[DIMS_REG_W-1:0];
				default:       thr_q  <= thr_q;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	// point wrap by reciprocal multiply, then remainder
	assign qa_prod = 31'(pa_raw_q) * 31'(RECIP);
	assign qb_prod = 31'(pb_raw_q) * 31'(RECIP);
	assign ra_rem  = 32'(pa_raw_q) - 32'(qa_q) * 32'(MAX_POINTS);
	assign rb_rem  = 32'(pb_raw_q) - 32'(qb_q) * 32'(MAX_POINTS);

	assign dims_ext = 7'(dims_q);
	assign last7    = (dims_ext == 7'd0) ? 7'd0 :
	                  (dims_ext > DIMS_V) ? (DIMS_V - 7'd1) : (dims_ext - 7'd1);
	assign slot_ok  = 7'(slot_q) < DIMS_V;

	assign ram_we  = (state_q == ST_RED2) && (op_q == OP_WRITE) && slot_ok;
	assign waddr   = {PT_W'(ra_rem[9:0]), SLOT_W'(slot_q)};
	assign ram_re  = (state_q == ST_RUN);
	assign raddr_a = {pa_q, j_q};
	assign raddr_b = {pb_q, j_q};

	pdf_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (coord_q),
		.re    (ram_re),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	pdf_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (coord_q),
		.re    (ram_re),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign diff    = $signed({rdata_a[31], rdata_a}) - $signed({rdata_b[31], rdata_b});
	assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
	assign sum_ext = 65'(sum_q) + 65'(sq_s3);

	assign exceed_a = {16'd0, sum_q, 16'd0} > prod_a_q;
	assign exceed_b = {16'd0, sum_q, 16'd0} > prod_b_q;

	// transaction payload and radius products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= op;
			pa_raw_q <= point_a;
			pb_raw_q <= point_b;
			slot_q   <= slot;
			coord_q  <= coord_value;
			ra_q     <= radius_a;
			rb_q     <= radius_b;
		end
		if (state_q == ST_RED1) begin
			qa_q  <= qa_prod[30:20];
			qb_q  <= qb_prod[30:20];
			r2a_q <= 64'(ra_q) * 64'(ra_q);
			r2b_q <= 64'(rb_q) * 64'(rb_q);
		end
		if (state_q == ST_RED2) begin
			pa_q   <= PT_W'(ra_rem[9:0]);
			pb_q   <= PT_W'(rb_rem[9:0]);
			last_q <= SLOT_W'(last7);
		end
		pla_q    <= 64'(r2a_q[31:0]) * 64'(thr_q);
		pha_q    <= 64'(r2a_q[63:32]) * 64'(thr_q);
		plb_q    <= 64'(r2b_q[31:0]) * 64'(thr_q);
		phb_q    <= 64'(r2b_q[63:32]) * 64'(thr_q);
		prod_a_q <= {32'd0, pla_q} + {pha_q, 32'd0};
		prod_b_q <= {32'd0, plb_q} + {phb_q, 32'd0};
		ad_s2    <= mag[31:0];
		sq_s3    <= 64'(ad_s2) * 64'(ad_s2);
		if (state_q == ST_CMP && out_free) begin
			filter_q <= exceed_a && exceed_b;
			dist_q   <= sum_q;
		end
	end

	// sequencer, read pipeline valids and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				sum_q <= sum_ext[64] ? '1 : sum_ext[63:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RED1;
					end
				end
				ST_RED1: begin
					state_q <= ST_RED2;
				end
				ST_RED2: begin
					j_q   <= '0;
					sum_q <= '0;
					state_q <= (op_q == OP_WRITE) ? ST_IDLE : ST_RUN;
				end
				ST_RUN: begin
					if (j_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign filter_pair = filter_q;
	assign distance_sq = dist_q;

	a_cmp_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> !v_s1 && !v_s2 && !v_s3)
		else $error("compare entered with reads in flight");

	a_result_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CMP))
		else $error("result raised outside compare");

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && state_q != ST_RED2 |=> sum_q >= $past(sum_q))
		else $error("accumulator decreased");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> j_q <= last_q)
		else $error("coordinate index past last");

	a_write_only_for_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re && !v_s1 && !v_s2 && !v_s3)
		else $error("store write overlaps a query read");

endmodule

// ===== hw/rtl/pdf_ram.sv =====
// pdf_ram: generic single-write, single-read synchronous ram
// read data registered, available in the cycle after re; no dependencies
module pdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for projection_distance_filter
// predicts distance_sq and filter_pair from a private copy of the coordinate store
// depends on pdf_pkg and the projection_distance_filter rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pdf_pkg::*;

	localparam int LIMIT = 600000;
	localparam int NPTS  = 1024;
	localparam int NDIM  = 16;

	typedef struct {
		logic        flag;
		logic [63:0] sq_dist;
	} pair_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  op = 1'b0;
	logic [POINT_W-1:0]    point_a = '0;
	logic [POINT_W-1:0]    point_b = '0;
	logic [SLOT_IN_W-1:0]  slot = '0;
	logic signed [COORD_W-1:0] coord_value = '0;
	logic [RADIUS_W-1:0]   radius_a = '0;
	logic [RADIUS_W-1:0]   radius_b = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  filter_pair;
	logic [DIST_W-1:0]     distance_sq;

	logic [31:0]  coord_copy [0:NPTS*NDIM-1];
	bit           coord_known [0:NPTS*NDIM-1];
	logic [31:0]  thr_copy = THRESHOLD_RST;
	logic [4:0]   dims_copy = DIMS_RST;
	pair_result_t pending_results [$];
	int           loaded_points [$];
	int           fail_count = 0;
	int           sent_items = 0;
	int           cycles = 0;
	int           send_idle = 0;
	int           recv_stall = 0;

	projection_distance_filter uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .point_a(point_a), .point_b(point_b), .slot(slot),
		.coord_value(coord_value), .radius_a(radius_a), .radius_b(radius_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.filter_pair(filter_pair), .distance_sq(distance_sq)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic int active_dims();
		if (dims_copy < 1)
			return 1;
		if (dims_copy > NDIM)
			return NDIM;
		return int'(dims_copy);
	endfunction

	function automatic logic [63:0] projected_distance(int pa, int pb, int m);
		logic [31:0] ca, cb, mag;
		logic [32:0] diff;
		logic [64:0] acc;
		acc = '0;
		for (int j = 0; j < m; j++) begin
			ca = coord_copy[pa*NDIM+j];
			cb = coord_copy[pb*NDIM+j];
			diff = {ca[31], ca} - {cb[31], cb};
			mag = diff[32] ? 32'(-diff) : diff[31:0];
			acc = acc + 65'(64'(mag) * 64'(mag));
			if (acc[64])
				acc = {1'b0, {64{1'b1}}};
		end
		return acc[63:0];
	endfunction

	function automatic bit beyond_radius(logic [63:0] d, logic [31:0] thr, logic [31:0] r);
		logic [95:0] lhs, rhs;
		lhs = {16'd0, d, 16'd0};
		rhs = 96'(thr) * 96'(r) * 96'(r);
		return lhs > rhs;
	endfunction

	function automatic bit point_ready(int p, int m);
		for (int j = 0; j < m; j++)
			if (!coord_known[p*NDIM+j])
				return 0;
		return 1;
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			default: v = 32'($signed($urandom) >>> $urandom_range(0, 31));
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_radius();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_item(op_t o, int pa, int pb, int sl, logic [31:0] cv,
			logic [31:0] ra, logic [31:0] rb);
		pair_result_t r;
		int m;
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		point_a     <= POINT_W'(pa);
		point_b     <= POINT_W'(pb);
		slot        <= SLOT_IN_W'(sl);
		coord_value <= cv;
		radius_a    <= ra;
		radius_b    <= rb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		if (o == OP_WRITE) begin
			coord_copy[pa*NDIM+sl] = cv;
			coord_known[pa*NDIM+sl] = 1;
		end else begin
			m = active_dims();
			r.sq_dist = projected_distance(pa, pb, m);
			r.flag = beyond_radius(r.sq_dist, thr_copy, ra)
				&& beyond_radius(r.sq_dist, thr_copy, rb);
			pending_results.push_back(r);
		end
	endtask

	task automatic write_coord(int p, int sl, logic [31:0] v);
		send_item(OP_WRITE, p, $urandom_range(0, NPTS-1), sl, v, $urandom, $urandom);
	endtask

	task automatic query_pair(int pa, int pb, logic [31:0] ra, logic [31:0] rb);
		send_item(OP_QUERY, pa, pb, $urandom_range(0, NDIM-1), $urandom, ra, rb);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic set_register(reg_idx_t idx, logic [31:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_THRESHOLD)
			thr_copy = data;
		else
			dims_copy = data[4:0];
	endtask

	// mostly queries; also full vector loads, stray and partial writes
	task automatic run_mix(int count);
		int start, m, p, a, b, r, k;
		int ready_pts [$];
		start = sent_items;
		while (sent_items - start < count) begin
			m = active_dims();
			ready_pts = {};
			foreach (loaded_points[i])
				if (point_ready(loaded_points[i], m))
					ready_pts.push_back(loaded_points[i]);
			r = $urandom_range(0, 99);
			if (ready_pts.size() < 2 || r < 25) begin
				p = $urandom_range(0, NPTS-1);
				for (int j = 0; j < m; j++)
					write_coord(p, j, rand_coord());
				loaded_points.push_back(p);
				b = ready_pts.size() ? ready_pts[$urandom_range(0, ready_pts.size()-1)] : p;
				query_pair(p, b, rand_radius(), rand_radius());
			end else if (r < 80) begin
				a = ready_pts[$urandom_range(0, ready_pts.size()-1)];
				b = ($urandom_range(0, 9) == 0) ? a
					: ready_pts[$urandom_range(0, ready_pts.size()-1)];
				query_pair(a, b, rand_radius(), rand_radius());
			end else if (r < 90) begin
				write_coord($urandom_range(0, NPTS-1), $urandom_range(0, NDIM-1), rand_coord());
			end else begin
				p = $urandom_range(0, NPTS-1);
				k = $urandom_range(0, m-1);
				for (int j = 0; j < k; j++)
					write_coord(p, j, rand_coord());
			end
		end
	endtask

	task automatic test_reset_settings();
		send_idle = 0;
		recv_stall = 0;
		run_mix(80);
	endtask

	task automatic test_directed_cases();
		set_register(REG_DIMS, 32'd2);
		send_idle = 0;
		recv_stall = 0;
		write_coord(0, 0, 32'h7FFF_FFFF);
		write_coord(0, 1, 32'h7FFF_FFFF);
		write_coord(1023, 0, 32'h8000_0000);
		write_coord(1023, 1, 32'h8000_0000);
		write_coord(5, 0, 32'h0001_0000);
		write_coord(5, 1, 32'h0);
		write_coord(6, 0, 32'h0);
		write_coord(6, 1, 32'h0);
		// saturated sum against zero and full radii, and a point against itself
		query_pair(0, 1023, 32'h0, 32'h0);
		query_pair(1023, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		query_pair(0, 0, 32'h0, 32'h0);
		// unit distance: both, neither, only one radius exceeded
		query_pair(5, 6, 32'h0, 32'h0);
		query_pair(5, 6, 32'h0001_0000, 32'h0001_0000);
		query_pair(5, 6, 32'h0, 32'h0001_0000);
		query_pair(6, 5, 32'h0000_0100, 32'h0000_0100);
		// equality at threshold one does not flag, a radius just below does
		set_register(REG_THRESHOLD, 32'h0001_0000);
		query_pair(5, 6, 32'h0001_0000, 32'h0001_0000);
		query_pair(5, 6, 32'h0000_FFFF, 32'h0000_FFFF);
		// zero dims acts as one
		set_register(REG_DIMS, 32'd0);
		query_pair(0, 1023, 32'h0, 32'h0);
		query_pair(1023, 0, 32'h0001_0000, 32'h0);
	endtask

	task automatic test_threshold_limits();
		set_register(REG_THRESHOLD, 32'h0);
		set_register(REG_DIMS, 32'd1);
		send_idle = 64;
		recv_stall = 0;
		run_mix(80);
		set_register(REG_THRESHOLD, 32'hFFFF_FFFF);
		set_register(REG_DIMS, 32'd16);
		send_idle = 0;
		recv_stall = 64;
		run_mix(80);
	endtask

	task automatic test_dims_clamp();
		set_register(REG_THRESHOLD, $urandom);
		set_register(REG_DIMS, 32'd31);
		send_idle = 37;
		recv_stall = 37;
		run_mix(80);
		set_register(REG_DIMS, {27'($urandom), 5'd0});
		run_mix(60);
		set_register(REG_DIMS, 32'd17);
		send_idle = 0;
		recv_stall = 0;
		run_mix(60);
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 2; round++) begin
			set_register(REG_THRESHOLD, $urandom >> $urandom_range(0, 24));
			set_register(REG_DIMS, {27'($urandom), 5'($urandom_range(1, 16))});
			send_idle = round ? 37 : 64;
			recv_stall = round ? 37 : 64;
			run_mix(60);
		end
	endtask

	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: filter_pair %0d distance_sq %h", filter_pair,
					distance_sq);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (filter_pair !== want.flag) begin
					$error("filter_pair: expected %0d, got %0d", want.flag, filter_pair);
					fail_count++;
				end
				if (distance_sq !== want.sq_dist) begin
					$error("distance_sq: expected %h, got %h", want.sq_dist, distance_sq);
					fail_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NPTS*NDIM; i++)
			coord_known[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_settings();
		test_directed_cases();
		test_threshold_limits();
		test_dims_clamp();
		test_random_settings();
		settle();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_ram.sv
hw/rtl/projection_distance_filter.sv
bench/testbench.sv
